FILE: rtl/tbpc_pkg.sv
// Shared types and constants for the touch button press classifier.
// No dependencies; used by tbpc_chan and touch_button_press_classifier.
package tbpc_pkg;

    localparam int RAW_W        = 16;
    localparam int TIME_W       = 32;
    localparam int KEEP_W       = 8;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int OUT_CH       = 3;

    localparam int CHANNELS_DEF  = 3;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [KEEP_W-1:0] KEEP_RST      = 8'd243;
    localparam logic [RAW_W-1:0]  THRESHOLD_RST = 16'd10;
    localparam logic [RAW_W-1:0]  LONG_MS_RST   = 16'd1000;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_SEED   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAGE_IDLE    = 2'd0,
        STAGE_PRESSED = 2'd1,
        STAGE_LONG    = 2'd2
    } stage_t;

    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2,
        PRESS_HOLD  = 2'd3
    } press_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BASELINE_KEEP   = 2'd0,
        REG_TOUCH_THRESHOLD = 2'd1,
        REG_LONG_PRESS_MS   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [KEEP_W-1:0] keep;
        logic [RAW_W-1:0]  threshold;
        logic [RAW_W-1:0]  long_ms;
    } cfg_t;

    // one item handed to a channel as it leaves the input register
    typedef struct packed {
        logic              en;
        logic              sample;
        logic              tick;
        logic              seed;
        logic [RAW_W-1:0]  raw;
        logic [TIME_W-1:0] now;
    } chan_cmd_t;

    typedef struct packed {
        logic   touched;
        press_t press;
    } chan_res_t;

endpackage

FILE: rtl/touch_button_press_classifier.sv
// Top level of the capacitive touch press classifier: stream ports,
// config registers, input and result registers. Depends on tbpc_pkg, tbpc_chan.
//
//  port group   dir  width  contents
//  s_t*         in   80+2   tdata raw_a,raw_b,raw_c,now_ms; tuser kind
//  m_t*         out  16     tdata touched_mask,press_a,press_b,press_c, pad
//  cfg_*        in   2+16   register write, index = register number
//
// One item per cycle sustained while m_tready stays high; an item goes through
// the input register, then channel logic into the result register.
// Channel state updates as the item moves from the input register to the
// result register. Reset clears config to defaults, baselines and histories
// to zero, press trackers to idle. A stalled result holds the input register;
// the input side keeps accepting while the result register can move.
module touch_button_press_classifier #(
    parameter int CHANNELS  = tbpc_pkg::CHANNELS_DEF,
    parameter int FRAC_BITS = tbpc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [79:0]                         s_tdata,   // raw_a, raw_b, raw_c, now_ms
    input  logic [1:0]                          s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // touched_mask, press_a/b/c, zero pad
    input  logic                                cfg_we,
    input  logic [tbpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int OC = tbpc_pkg::OUT_CH;

    tbpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keep      <= tbpc_pkg::KEEP_RST;
            cfg_reg.threshold <= tbpc_pkg::THRESHOLD_RST;
            cfg_reg.long_ms   <= tbpc_pkg::LONG_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tbpc_pkg::REG_BASELINE_KEEP:
                    cfg_reg.keep <= cfg_wdata[tbpc_pkg::KEEP_W-1:0];
                tbpc_pkg::REG_TOUCH_THRESHOLD:
                    cfg_reg.threshold <= cfg_wdata;
                tbpc_pkg::REG_LONG_PRESS_MS:
                    cfg_reg.long_ms <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    logic                              in_valid_reg;
    logic [79:0]                       in_data_reg;
    logic [1:0]                        in_kind_reg;
    logic                              out_valid_reg;
    logic [15:0]                       out_data_reg;
    logic                              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
    end

    logic [tbpc_pkg::RAW_W-1:0] raw_in [OC];
    assign raw_in[0] = in_data_reg[15:0];
    assign raw_in[1] = in_data_reg[31:16];
    assign raw_in[2] = in_data_reg[47:32];

    logic [OC-1:0]     mask;
    tbpc_pkg::press_t  press [OC];
    tbpc_pkg::chan_res_t res [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        tbpc_pkg::chan_cmd_t cmd;
        assign cmd.en     = advance;
        assign cmd.sample = (in_kind_reg == tbpc_pkg::KIND_SAMPLE);
        assign cmd.tick   = (in_kind_reg == tbpc_pkg::KIND_TICK);
        assign cmd.seed   = (in_kind_reg == tbpc_pkg::KIND_SEED);
        assign cmd.now    = in_data_reg[79:48];
        if (c < OC)
        begin : g_raw
            assign cmd.raw = raw_in[c];
        end
        else
        begin : g_zero
            assign cmd.raw = '0;
        end

        tbpc_chan #(
            .FRAC_BITS (FRAC_BITS)
        ) u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .cfg   (cfg_reg),
            .cmd   (cmd),
            .res   (res[c])
        );
    end

    for (genvar c = 0; c < OC; c++)
    begin : g_out
        if (c < CHANNELS)
        begin : g_live
            assign mask[c]  = res[c].touched;
            assign press[c] = res[c].press;
        end
        else
        begin : g_none
            assign mask[c]  = 1'b0;
            assign press[c] = tbpc_pkg::PRESS_NONE;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {7'd0, press[2], press[1], press[0], mask};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input register dropped a stalled item");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input not ready with empty result register");

    a_seed_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_kind_reg == tbpc_pkg::KIND_SEED |=> m_tdata[2:0] == 3'b000)
        else $error("seed left a channel touched");

    a_press_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_kind_reg != tbpc_pkg::KIND_TICK |=> m_tdata[8:3] == 6'd0)
        else $error("press event on a non-tick item");

endmodule

FILE: rtl/tbpc_chan.sv
// One touch channel: baseline filter, three-deep over history, press tracker.
// Depends on tbpc_pkg.
module tbpc_chan #(
    parameter int FRAC_BITS = tbpc_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tbpc_pkg::cfg_t      cfg,
    input  tbpc_pkg::chan_cmd_t cmd,
    output tbpc_pkg::chan_res_t res
);

    localparam int BW = tbpc_pkg::RAW_W + FRAC_BITS;
    localparam int KW = tbpc_pkg::KEEP_W;

    logic [BW-1:0]                 base_reg, base_next;
    logic [2:0]                    hist_reg, hist_next;
    tbpc_pkg::stage_t              stage_reg, stage_next;
    logic [tbpc_pkg::TIME_W-1:0]   start_reg, start_next;

    logic [BW-1:0]      rawf;
    logic [BW-1:0]      thrf;
    logic [BW+KW-1:0]   prod_old;
    logic [BW+KW:0]     prod_new;
    logic [BW+KW:0]     acc;
    logic [BW-1:0]      base_upd;
    logic signed [BW:0] diff;
    logic               over;
    logic               touched;
    logic [tbpc_pkg::TIME_W-1:0] elapsed;
    logic               long_due;
    tbpc_pkg::press_t   press;

    assign rawf = {cmd.raw, {FRAC_BITS{1'b0}}};
    assign thrf = {cfg.threshold, {FRAC_BITS{1'b0}}};

    // (b*k + raw*(256-k)) >> 8, result stays inside BW bits
    assign prod_old = base_reg * cfg.keep;
    assign prod_new = rawf * ((KW+1)'(1 << KW) - {1'b0, cfg.keep});
    assign acc      = {1'b0, prod_old} + prod_new;
    assign base_upd = acc[BW+KW-1:KW];

    assign diff = $signed({1'b0, base_upd}) - $signed({1'b0, rawf});
    assign over = diff > $signed({1'b0, thrf});

    assign touched  = (hist_reg == 3'b111);
    assign elapsed  = cmd.now - start_reg;
    assign long_due = elapsed >= {{(tbpc_pkg::TIME_W-tbpc_pkg::RAW_W){1'b0}}, cfg.long_ms};

    always_comb
    begin
        base_next  = base_reg;
        hist_next  = hist_reg;
        stage_next = stage_reg;
        start_next = start_reg;
        press      = tbpc_pkg::PRESS_NONE;
        if (cmd.sample)
        begin
            base_next = base_upd;
            hist_next = {hist_reg[1:0], over};
        end
        else if (cmd.seed)
        begin
            base_next = rawf;
            hist_next = 3'b000;
        end
        else if (cmd.tick)
        begin
            unique case (stage_reg)
                tbpc_pkg::STAGE_PRESSED, tbpc_pkg::STAGE_LONG:
                begin
                    if (touched && long_due)
                    begin
                        press      = (stage_reg == tbpc_pkg::STAGE_PRESSED) ?
                                     tbpc_pkg::PRESS_LONG : tbpc_pkg::PRESS_HOLD;
                        stage_next = tbpc_pkg::STAGE_LONG;
                    end
                    else if (!touched)
                    begin
                        if (stage_reg == tbpc_pkg::STAGE_PRESSED)
                        begin
                            press = tbpc_pkg::PRESS_SHORT;
                        end
                        stage_next = tbpc_pkg::STAGE_IDLE;
                    end
                end
                default:
                begin
                    // idle (or the unreachable fourth code)
                    if (touched)
                    begin
                        stage_next = tbpc_pkg::STAGE_PRESSED;
                        start_next = cmd.now;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            hist_reg  <= '0;
            stage_reg <= tbpc_pkg::STAGE_IDLE;
            start_reg <= '0;
        end
        else if (cmd.en)
        begin
            base_reg  <= base_next;
            hist_reg  <= hist_next;
            stage_reg <= stage_next;
            start_reg <= start_next;
        end
    end

    assign res.touched = (hist_next == 3'b111);
    assign res.press   = press;

endmodule

FILE: tb/press_event_checker.sv
`timescale 1ns / 1ps
// Checker for the touch press classifier: watches the input, result and register
// write ports, predicts every result and compares it. Depends on tbpc_pkg.
module press_event_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [79:0]                     s_tdata,   // raw_a, raw_b, raw_c, now_ms
    input  logic [1:0]                      s_tuser,   // kind
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,   // touched_mask, press_a/b/c, zero pad
    input  logic                            cfg_we,
    input  logic [tbpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending
);

    localparam int MAX_REPORTS = 50;

    logic [23:0]       baseline_fx [3];
    logic [2:0]        over_hist [3];
    tbpc_pkg::stage_t  stage [3];
    logic [31:0]       press_t0 [3];
    logic [7:0]        keep;
    logic [15:0]       threshold;
    logic [15:0]       long_ms;

    logic [15:0] expected_results [$];
    int          errors;

    // Moves the channel state by one item and returns the packed result word.
    function automatic logic [15:0] advance_channels(input logic [1:0] kind,
                                                     input logic [79:0] data);
        logic [15:0] raw;
        logic [31:0] now;
        logic [31:0] elapsed;
        logic [63:0] rawf;
        logic [63:0] next_base;
        longint      drop;
        longint      limit;
        logic        over;
        logic        touched;
        logic [2:0]  mask;
        tbpc_pkg::press_t ev [3];

        now = data[79:48];
        for (int c = 0; c < 3; c++)
        begin
            raw = data[16*c +: 16];
            ev[c] = tbpc_pkg::PRESS_NONE;
            rawf = {40'd0, raw, 8'd0};
            case (kind)
                tbpc_pkg::KIND_SAMPLE:
                begin
                    next_base = (64'(baseline_fx[c]) * 64'(keep)
                                 + rawf * (64'd256 - 64'(keep))) >> 8;
                    baseline_fx[c] = next_base[23:0];
                    drop = longint'(next_base[23:0]) - longint'(rawf);
                    limit = longint'({threshold, 8'd0});
                    over = drop > limit;
                    over_hist[c] = {over_hist[c][1:0], over};
                end
                tbpc_pkg::KIND_TICK:
                begin
                    touched = over_hist[c] == 3'b111;
                    elapsed = now - press_t0[c];
                    if (touched && stage[c] == tbpc_pkg::STAGE_IDLE)
                    begin
                        stage[c] = tbpc_pkg::STAGE_PRESSED;
                        press_t0[c] = now;
                    end
                    else if (touched && stage[c] != tbpc_pkg::STAGE_IDLE
                             && elapsed >= 32'(long_ms))
                    begin
                        ev[c] = (stage[c] == tbpc_pkg::STAGE_PRESSED) ?
                                tbpc_pkg::PRESS_LONG : tbpc_pkg::PRESS_HOLD;
                        stage[c] = tbpc_pkg::STAGE_LONG;
                    end
                    else if (!touched && stage[c] == tbpc_pkg::STAGE_PRESSED)
                    begin
                        stage[c] = tbpc_pkg::STAGE_IDLE;
                        ev[c] = tbpc_pkg::PRESS_SHORT;
                    end
                    else if (!touched && stage[c] == tbpc_pkg::STAGE_LONG)
                        stage[c] = tbpc_pkg::STAGE_IDLE;
                end
                tbpc_pkg::KIND_SEED:
                begin
                    baseline_fx[c] = {raw, 8'd0};
                    over_hist[c] = 3'b000;
                end
                default: ;
            endcase
        end
        for (int c = 0; c < 3; c++)
            mask[c] = over_hist[c] == 3'b111;
        return {7'd0, ev[2], ev[1], ev[0], mask};
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] want;
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                baseline_fx[c] = '0;
                over_hist[c] = '0;
                stage[c] = tbpc_pkg::STAGE_IDLE;
                press_t0[c] = '0;
            end
            keep = tbpc_pkg::KEEP_RST;
            threshold = tbpc_pkg::THRESHOLD_RST;
            long_ms = tbpc_pkg::LONG_MS_RST;
            expected_results.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    tbpc_pkg::REG_BASELINE_KEEP:   keep = cfg_wdata[7:0];
                    tbpc_pkg::REG_TOUCH_THRESHOLD: threshold = cfg_wdata;
                    tbpc_pkg::REG_LONG_PRESS_MS:   long_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_channels(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: result transfer with nothing expected, %s %h",
                                 $time, "expected none, actual", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("touched_mask", want[2:0], m_tdata[2:0]);
                    check_field("press_a", want[4:3], m_tdata[4:3]);
                    check_field("press_b", want[6:5], m_tdata[6:5]);
                    check_field("press_c", want[8:7], m_tdata[8:7]);
                    check_field("pad", want[15:9], m_tdata[15:9]);
                end
            end
            fail_count <= errors;
            pending <= expected_results.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the touch press classifier bench: clock, reset, stimulus, stalls and verdict.
// Depends on tbpc_pkg, touch_button_press_classifier and press_event_checker.
module testbench;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASES         = 6;
    localparam int         PHASE_ITEMS    = 140;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;     // raw_a, raw_b, raw_c, now_ms
    logic [1:0]  s_tuser = '0;     // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // touched_mask, press_a/b/c, zero pad
    logic        cfg_we = 1'b0;
    logic [tbpc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [tbpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          kind_count [4] = '{default: 0};
    int          items_sent = 0;
    bit          burst = 1'b0;

    logic [31:0] tick_time;
    logic [7:0]  cur_keep = tbpc_pkg::KEEP_RST;
    logic [15:0] cur_thr = tbpc_pkg::THRESHOLD_RST;
    logic [15:0] cur_long = tbpc_pkg::LONG_MS_RST;

    touch_button_press_classifier dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    press_event_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // mostly short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (burst)
                m_tready <= 1'b1;
            else if (hold > 0)
                hold--;
            else if ($urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                hold = idle_span();
            end
            else
            begin
                m_tready <= 1'b1;
                hold = $urandom_range(0, 8);
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [15:0] ra,
                             input logic [15:0] rb, input logic [15:0] rc,
                             input logic [31:0] now);
        int gap;
        gap = (burst || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {now, rc, rb, ra};
        do @(posedge clk); while (!s_tready);
        kind_count[kind]++;
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] k, input logic [15:0] thr,
                                input logic [15:0] lng);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= tbpc_pkg::REG_BASELINE_KEEP;
        cfg_wdata <= {8'd0, k};
        @(posedge clk);
        cfg_addr <= tbpc_pkg::REG_TOUCH_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_addr <= tbpc_pkg::REG_LONG_PRESS_MS;
        cfg_wdata <= lng;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_keep = k;
        cur_thr = thr;
        cur_long = lng;
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom);
    endtask

    function automatic logic [31:0] tick_advance();
        int r;
        int l;
        r = $urandom_range(0, 9);
        l = int'(cur_long);
        if (r < 4)
            return $urandom_range(0, l / 4 + 1);
        else if (r < 8)
            return (l > 2) ? $urandom_range(l - 2, l + 2) : $urandom_range(0, 4);
        return $urandom_range(0, 3 * l + 10);
    endfunction

    // seed, then a run of samples with fingers landing and lifting, mixed with ticks
    task automatic press_session();
        logic [15:0] level [3];
        logic [15:0] rv [3];
        bit          finger [3];
        int          steps;
        int          v;

        burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0)
            tick_time = 32'hFFFF_F000 + $urandom_range(0, 16'hFFF);
        for (int c = 0; c < 3; c++)
        begin
            if ($urandom_range(0, 9) == 0)
                level[c] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                level[c] = 16'($urandom_range(16'h0800, 16'hF800));
            finger[c] = 1'($urandom_range(0, 1));
        end
        send_item(tbpc_pkg::KIND_SEED, level[0], level[1], level[2], $urandom);
        steps = $urandom_range(8, 40);
        repeat (steps)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                tick_time = tick_time + tick_advance();
                send_item(tbpc_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                          tick_time);
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if ($urandom_range(0, 5) == 0)
                        finger[c] = !finger[c];
                    if (finger[c])
                        v = int'(level[c]) - int'(cur_thr) - $urandom_range(1, 4000);
                    else
                        v = int'(level[c]) + $urandom_range(0, 16) - 8;
                    rv[c] = (v < 0) ? 16'h0000 : (v > 65535) ? 16'hFFFF : 16'(v);
                end
                send_item(tbpc_pkg::KIND_SAMPLE, rv[0], rv[1], rv[2], $urandom);
            end
        end
    endtask

    task automatic run_phase(input int count);
        int first;
        bit paused;
        first = items_sent;
        paused = 1'b0;
        while (items_sent - first < count)
        begin
            // hold the sender once per phase until the pipeline is empty
            if (!paused && items_sent - first >= count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 4) != 0)
                press_session();
            else
            begin
                burst = 1'b0;
                repeat ($urandom_range(1, 4)) send_noise();
            end
        end
    endtask

    task automatic run_directed();
        send_item(tbpc_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(tbpc_pkg::KIND_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
        send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(tbpc_pkg::KIND_SEED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
        repeat (3)
            send_item(tbpc_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        // press starts just before the time wraps; long is reached across the wrap
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFF0);
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_03D7);
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_03D8);
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_03D8);
        send_item(tbpc_pkg::KIND_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0400);
        send_item(tbpc_pkg::KIND_SEED, 16'h8000, 16'h0001, 16'hFFFF, 32'h0000_0000);
        repeat (3)
            send_item(tbpc_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0500);
        // release before long: short press on channel 0
        send_item(tbpc_pkg::KIND_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
        send_item(tbpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0501);
    endtask

    initial
    begin
        logic [7:0]  keep_set [PHASES];
        logic [15:0] thr_set [PHASES];
        logic [15:0] long_set [PHASES];

        keep_set = '{8'd243, 8'd255, 8'd0, 8'd128, 8'($urandom_range(200, 255)), 8'd250};
        thr_set  = '{16'd10, 16'd0, 16'd65535, 16'd300, 16'($urandom_range(0, 2000)), 16'd50};
        long_set = '{16'd1000, 16'd0, 16'd65535, 16'd20, 16'($urandom_range(1, 3000)), 16'd500};
        tick_time = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // the first phase runs on the reset values
            if (ph > 0)
                apply_config(keep_set[ph], thr_set[ph], long_set[ph]);
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (10) @(posedge clk);
        $display("Covered %0d transfers in: %0d samples, %0d ticks, %0d seeds, %0d unused kind",
                 items_sent, kind_count[tbpc_pkg::KIND_SAMPLE],
                 kind_count[tbpc_pkg::KIND_TICK], kind_count[tbpc_pkg::KIND_SEED],
                 kind_count[KIND_UNUSED]);
        $display("across %0d register settings, extremes of keep, threshold and long time",
                 PHASES);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
